/* hw/rtl/tga_rle_image_encoder_core_macros.svh */
// assertion macros for the tga run-length encoder
// used by tga_rle_image_encoder_core, relies on i_clk and i_rst_n in scope
`ifndef TGA_RLE_IMAGE_ENCODER_CORE_MACROS_SVH
`define TGA_RLE_IMAGE_ENCODER_CORE_MACROS_SVH

// property must hold at every clock edge out of reset
`define TGA_RLE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// condition must never be seen out of reset
`define TGA_RLE_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

/* hw/rtl/tga_rle_pkg.sv */
// shared types and constants of the tga run-length encoder
// no dependencies
`timescale 1ns / 1ps

package tga_rle_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_COLOR_MODE   = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

    // header byte positions and values
    localparam logic [4:0] HDR_TYPE_POS     = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO     = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI     = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO    = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI    = 5'd15;
    localparam logic [4:0] HDR_DEPTH_POS    = 5'd16;
    localparam logic [4:0] HDR_LAST_POS     = 5'd17;

    localparam logic [7:0] IMG_TYPE_COLOR   = 8'd10;
    localparam logic [7:0] IMG_TYPE_GREY    = 8'd11;
    localparam logic [7:0] DEPTH_COLOR      = 8'd24;
    localparam logic [7:0] DEPTH_GREY       = 8'd8;

    // packet count byte is bias plus run length
    localparam logic [7:0] RUN_BIAS         = 8'd127;

    // packet byte positions
    localparam logic [4:0] PKT_LAST_COLOR   = 5'd3;
    localparam logic [4:0] PKT_LAST_GREY    = 5'd1;
    localparam logic [1:0] PKT_COUNT_POS    = 2'd0;
    localparam logic [1:0] PKT_BYTE0_POS    = 2'd1;
    localparam logic [1:0] PKT_BYTE1_POS    = 2'd2;

    // byte job produced by one pixel
    typedef struct packed {
        logic        hdr;         // header still to send
        logic        pa;          // closed run packet still to send
        logic        pb;          // flushed run packet still to send
        logic        frame_last;  // job ends the file
        logic [7:0]  pa_cnt;
        logic [23:0] pa_pix;
        logic [7:0]  pb_cnt;
        logic [23:0] pb_pix;
    } t_job;

endpackage

/* hw/rtl/tga_rle_pix_if.sv */
// pixel channel of the tga run-length encoder
// no dependencies
`timescale 1ns / 1ps

interface tga_rle_pix_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_value;
    logic        last_pixel;

    modport source (output valid, output pixel_value, output last_pixel, input ready);
    modport sink   (input valid, input pixel_value, input last_pixel, output ready);
endinterface

/* hw/rtl/tga_rle_byte_if.sv */
// byte stream channel of the tga run-length encoder
// no dependencies
`timescale 1ns / 1ps

interface tga_rle_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       item_last;
    logic       frame_end;

    modport source (output valid, output out_byte, output item_last, output frame_end,
                    input ready);
    modport sink   (input valid, input out_byte, input item_last, input frame_end,
                    output ready);
endinterface

/* hw/rtl/tga_rle_image_encoder_core.sv */
// channel   dir  request holds
// i_pix     in   pixel_value[23:0], last_pixel
// o_byte    out  out_byte[7:0], item_last, frame_end
// i_cfg_*   in   write enable, register index, 16-bit data
//
// a pixel merged into an open run is taken and sends nothing
// a pixel that sends bytes holds the byte serializer until they are out:
// 2 or 4 per packet, plus 18 when it opens a frame; one byte leaves per cycle
// while o_byte.ready is high; one job buffer sits ahead of the serializer, so
// the next pixel is taken while bytes are still going out; a stalled output stops both after that
// reset is synchronous and active low; the first pixel after it sends a header
// depends on tga_rle_pkg, tga_rle_pix_if, tga_rle_byte_if and the macros header
`timescale 1ns / 1ps
`include "tga_rle_image_encoder_core_macros.svh"

module tga_rle_image_encoder_core #(
    parameter int MAX_RUN = 127
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tga_rle_pix_if.sink           i_pix,
    tga_rle_byte_if.source        o_byte,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [15:0]           i_cfg_data
);

    localparam int CW = $clog2(MAX_RUN + 1);

    // configuration
    logic        r_color_mode;
    logic [15:0] r_image_width;
    logic [15:0] r_image_height;

    // run state
    logic [CW-1:0] r_run_count, n_run_count;
    logic [23:0]   r_run_pixel, n_run_pixel;
    logic          r_header_due, n_header_due;

    // job buffer and serializer
    tga_rle_pkg::t_job r_pend, n_job, r_act;
    logic              r_pend_valid;
    logic [4:0]        r_seg;

    logic          in_acc, out_acc;
    logic [CW-1:0] cnt0;
    logic          mismatch;
    logic [23:0]   mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode   <= 1'b0;
            r_image_width  <= '0;
            r_image_height <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tga_rle_pkg::CFG_COLOR_MODE:   r_color_mode   <= i_cfg_data[0];
                tga_rle_pkg::CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                tga_rle_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // run tracking and job building for an accepted pixel
    assign in_acc = i_pix.valid && i_pix.ready;
    assign mask   = r_color_mode ? 24'hFFFFFF : 24'h0000FF;
    assign cnt0   = r_header_due ? '0 : r_run_count;
    assign mismatch = ((r_run_pixel ^ i_pix.pixel_value) & mask) != 24'd0;

    always_comb begin
        n_job        = '0;
        n_job.hdr    = r_header_due;
        n_job.pa_pix = r_run_pixel;
        n_job.pa_cnt = tga_rle_pkg::RUN_BIAS + 8'(cnt0);
        n_run_pixel  = i_pix.pixel_value;
        n_run_count  = CW'(1);
        if (cnt0 != '0) begin
            if (mismatch || (cnt0 >= CW'(MAX_RUN))) begin
                n_job.pa = 1'b1;
            end else begin
                n_run_pixel = r_run_pixel;
                n_run_count = cnt0 + CW'(1);
            end
        end
        n_job.pb_pix = n_run_pixel;
        n_job.pb_cnt = tga_rle_pkg::RUN_BIAS + 8'(n_run_count);
        n_header_due = 1'b0;
        if (i_pix.last_pixel) begin
            n_job.pb         = 1'b1;
            n_job.frame_last = 1'b1;
            n_run_count      = '0;
            n_header_due     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_count  <= '0;
            r_run_pixel  <= '0;
            r_header_due <= 1'b1;
        end else if (in_acc) begin
            r_run_count  <= n_run_count;
            r_run_pixel  <= n_run_pixel;
            r_header_due <= n_header_due;
        end
    end

    // serializer: header, closed packet, flushed packet, in that order
    logic        seg_hdr, seg_pa, seg_end, more, act_valid, act_done, act_free;
    logic [7:0]  hdr_byte, pkt_byte, pkt_cnt;
    logic [23:0] pkt_pix;
    logic [4:0]  pkt_last;

    assign act_valid = r_act.hdr || r_act.pa || r_act.pb;
    assign seg_hdr   = r_act.hdr;
    assign seg_pa    = !r_act.hdr && r_act.pa;
    assign pkt_cnt   = seg_pa ? r_act.pa_cnt : r_act.pb_cnt;
    assign pkt_pix   = seg_pa ? r_act.pa_pix : r_act.pb_pix;
    assign pkt_last  = r_color_mode ? tga_rle_pkg::PKT_LAST_COLOR : tga_rle_pkg::PKT_LAST_GREY;
    assign seg_end   = seg_hdr ? (r_seg == tga_rle_pkg::HDR_LAST_POS) : (r_seg == pkt_last);
    assign more      = seg_hdr ? (r_act.pa || r_act.pb) : (seg_pa && r_act.pb);

    always_comb begin
        case (r_seg)
            tga_rle_pkg::HDR_TYPE_POS:
                hdr_byte = r_color_mode ? tga_rle_pkg::IMG_TYPE_COLOR : tga_rle_pkg::IMG_TYPE_GREY;
            tga_rle_pkg::HDR_WIDTH_LO:  hdr_byte = r_image_width[7:0];
            tga_rle_pkg::HDR_WIDTH_HI:  hdr_byte = r_image_width[15:8];
            tga_rle_pkg::HDR_HEIGHT_LO: hdr_byte = r_image_height[7:0];
            tga_rle_pkg::HDR_HEIGHT_HI: hdr_byte = r_image_height[15:8];
            tga_rle_pkg::HDR_DEPTH_POS:
                hdr_byte = r_color_mode ? tga_rle_pkg::DEPTH_COLOR : tga_rle_pkg::DEPTH_GREY;
            default:                    hdr_byte = 8'd0;
        endcase
    end

    always_comb begin
        case (r_seg[1:0])
            tga_rle_pkg::PKT_COUNT_POS: pkt_byte = pkt_cnt;
            tga_rle_pkg::PKT_BYTE0_POS: pkt_byte = pkt_pix[7:0];
            tga_rle_pkg::PKT_BYTE1_POS: pkt_byte = pkt_pix[15:8];
            default:                    pkt_byte = pkt_pix[23:16];
        endcase
    end

    assign o_byte.valid     = act_valid;
    assign o_byte.out_byte  = seg_hdr ? hdr_byte : pkt_byte;
    assign o_byte.item_last = seg_end && !more;
    assign o_byte.frame_end = seg_end && !more && r_act.frame_last;

    assign out_acc  = o_byte.valid && o_byte.ready;
    assign act_done = out_acc && seg_end && !more;
    assign act_free = !act_valid || act_done;

    assign i_pix.ready = !r_pend_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend       <= '0;
            r_act        <= '0;
            r_seg        <= '0;
        end else begin
            // merged pixels other than the last send nothing and never take the buffer
            if (in_acc && (n_job.hdr || n_job.pa || n_job.pb)) begin
                r_pend       <= n_job;
                r_pend_valid <= 1'b1;
            end else if (r_pend_valid && act_free) begin
                r_pend_valid <= 1'b0;
            end

            if (r_pend_valid && act_free) begin
                r_act <= r_pend;
                r_seg <= '0;
            end else if (out_acc) begin
                if (seg_end) begin
                    r_seg <= '0;
                    if (seg_hdr) begin
                        r_act.hdr <= 1'b0;
                    end else if (seg_pa) begin
                        r_act.pa <= 1'b0;
                    end else begin
                        r_act.pb <= 1'b0;
                    end
                end else begin
                    r_seg <= r_seg + 5'd1;
                end
            end
        end
    end

    `TGA_RLE_ASSERT(a_frame_end_is_item_last,
        o_byte.valid && o_byte.frame_end |-> o_byte.item_last, "frame end without item last")
    `TGA_RLE_ASSERT(a_pend_has_bytes,
        r_pend_valid |-> (r_pend.hdr || r_pend.pa || r_pend.pb), "empty job buffered")
    `TGA_RLE_ASSERT(a_frame_last_flushes,
        r_pend_valid && r_pend.frame_last |-> r_pend.pb, "frame end without flush packet")
    `TGA_RLE_ASSERT(a_header_opens_run,
        in_acc && r_header_due && !i_pix.last_pixel |=> !r_header_due && (r_run_count == CW'(1)),
        "frame start did not open a run")

endmodule
